// ===== hdl/rab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rab_pkg
// Shared types, register codes and channel tables for the RGB565 blend core.
// ----------------------------------------------------------------------------
package rab_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_COLOR = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_SWAP  = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [7:0] ALPHA_ZERO = 8'd0;
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  typedef logic [7:0] widen5_t [0:31];
  typedef logic [7:0] widen6_t [0:63];

  // Elaboration-time builders for the c*255/max widening tables
  function automatic widen5_t build_widen5();
    widen5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic widen6_t build_widen6();
    widen6_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam widen5_t WIDEN5 = build_widen5();
  localparam widen6_t WIDEN6 = build_widen6();

  // Channel order in the stage payloads: 2 red, 1 green, 0 blue
  typedef struct packed {
    logic [2:0][7:0] src;
    logic [2:0][7:0] dst;
    logic [15:0]     stored;
  } widen_stage_t;

  typedef struct packed {
    logic [2:0][15:0] sum;
    logic [15:0]      stored;
  } mix_stage_t;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        swap;
  } blend_cfg_t;

  function automatic logic [15:0] swap_word(input logic [15:0] w, input logic en);
    return en ? {w[7:0], w[15:8]} : w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rab_widen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rab_widen
// Stage 1: bring the stored word to native order and widen every channel of
// pixel and blend colour to 8 bits.
// ----------------------------------------------------------------------------
module rab_widen (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rab_pkg::blend_cfg_t   cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [15:0]           stored_pixel,
  output logic                       valid,
  input  wire logic                  out_ready,
  output rab_pkg::widen_stage_t      stage
);

  rab_pkg::widen_stage_t stage_next;
  logic [15:0]           native;
  logic                  load;

  assign in_ready = !valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    native                = rab_pkg::swap_word(stored_pixel, cfg.swap);
    stage_next.stored     = stored_pixel;
    stage_next.src[2]     = rab_pkg::WIDEN5[cfg.color[15:11]];
    stage_next.src[1]     = rab_pkg::WIDEN6[cfg.color[10:5]];
    stage_next.src[0]     = rab_pkg::WIDEN5[cfg.color[4:0]];
    stage_next.dst[2]     = rab_pkg::WIDEN5[native[15:11]];
    stage_next.dst[1]     = rab_pkg::WIDEN6[native[10:5]];
    stage_next.dst[0]     = rab_pkg::WIDEN5[native[4:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= stage_next;
    end
  end

  // A held item must not change while the next stage is full
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(stage))
    else $error("widen stage lost or changed a held item");

endmodule
`default_nettype wire

// ===== hdl/rab_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rab_mix
// Stage 2: weighted sum src*alpha + dst*(255-alpha) for each channel.
// ----------------------------------------------------------------------------
module rab_mix (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            alpha,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rab_pkg::widen_stage_t in_stage,
  output logic                       valid,
  input  wire logic                  out_ready,
  output rab_pkg::mix_stage_t        stage
);

  rab_pkg::mix_stage_t stage_next;
  logic [7:0]          beta;
  logic                load;

  assign in_ready = !valid || out_ready;
  assign load     = in_valid && in_ready;
  assign beta     = rab_pkg::ALPHA_FULL - alpha;

  always_comb begin
    stage_next.stored = in_stage.stored;
    for (int c = 0; c < 3; c++) begin
      stage_next.sum[c] = 16'(in_stage.src[c] * alpha) + 16'(in_stage.dst[c] * beta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= stage_next;
    end
  end

  // Weights add to 255, so no channel sum can pass 255*255
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> stage.sum[0] <= 16'd65025 && stage.sum[1] <= 16'd65025
              && stage.sum[2] <= 16'd65025)
    else $error("channel sum out of range");

endmodule
`default_nettype wire

// ===== hdl/rab_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rab_scale
// Stage 3: divide by 255, narrow to 5/6 bits, repack, restore byte order and
// apply the transparent and opaque cases. Holds the output register.
// ----------------------------------------------------------------------------
module rab_scale (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rab_pkg::blend_cfg_t   cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rab_pkg::mix_stage_t   in_stage,
  output logic                       valid,
  input  wire logic                  out_ready,
  output logic [15:0]                pixel
);

  logic [2:0][7:0] quot;
  logic [16:0]     tmp [3];
  logic [15:0]     packed_px;
  logic [15:0]     pixel_next;
  logic            load;

  assign in_ready = !valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    // floor(v/255) = (v + (v >> 8) + 1) >> 8 for v up to 255*255
    for (int c = 0; c < 3; c++) begin
      tmp[c]  = {1'b0, in_stage.sum[c]} + 17'(in_stage.sum[c][15:8]) + 17'd1;
      quot[c] = tmp[c][15:8];
    end
    packed_px = {quot[2][7:3], quot[1][7:2], quot[0][7:3]};
    if (cfg.alpha == rab_pkg::ALPHA_ZERO) begin
      pixel_next = in_stage.stored;
    end else if (cfg.alpha == rab_pkg::ALPHA_FULL) begin
      pixel_next = rab_pkg::swap_word(cfg.color, cfg.swap);
    end else begin
      pixel_next = rab_pkg::swap_word(packed_px, cfg.swap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel <= pixel_next;
    end
  end

  a_transparent: assert property (@(posedge clk) disable iff (rst)
    load && cfg.alpha == rab_pkg::ALPHA_ZERO |=> pixel == $past(in_stage.stored))
    else $error("transparent blend changed the pixel");

  a_opaque: assert property (@(posedge clk) disable iff (rst)
    load && cfg.alpha == rab_pkg::ALPHA_FULL
    |=> pixel == rab_pkg::swap_word($past(cfg.color), $past(cfg.swap)))
    else $error("opaque blend did not write the colour");

endmodule
`default_nettype wire

// ===== hdl/rgb565_alpha_blend_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb565_alpha_blend_core
// Constant-alpha blend of streamed RGB565 framebuffer words.
// ----------------------------------------------------------------------------
// Usage:
//   Program blend_color (0x0), blend_alpha (0x4) and byte_swap (0x8) over the
//   APB port while no pixel is in flight; pready is tied high.
//   Pixels enter on pixel_valid/pixel_stall with stored_pixel; a transfer
//   happens when valid is high and stall is low. Results leave on
//   result_valid/result_stall with blended_pixel in stored byte order.
//   From input transfer to result_valid a pixel passes the widen stage, the
//   multiply/add stage and the divide-and-pack stage with the output register.
//   Throughput is one pixel per cycle; each stage holds its item only while
//   the stage after it is full, so a stall on the result side fills the
//   three stages and then raises pixel_stall, with nothing lost or repeated.
//   Reset (synchronous, active high) empties the pipeline and clears all
//   three registers to zero.
// ----------------------------------------------------------------------------
module rgb565_alpha_blend_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rab_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rab_pkg::DATA_W-1:0]  pwdata,
  output logic      [rab_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        pixel_valid,
  output logic                             pixel_stall,
  input  wire logic [15:0]                 stored_pixel,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic      [15:0]                 blended_pixel
);

  rab_pkg::blend_cfg_t   cfg;
  rab_pkg::widen_stage_t widen_stage;
  rab_pkg::mix_stage_t   mix_stage;
  logic                  pixel_ready;
  logic                  widen_valid;
  logic                  mix_ready;
  logic                  mix_valid;
  logic                  scale_ready;
  logic                  wr_en;
  logic [1:0]            reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color <= '0;
      cfg.alpha <= '0;
      cfg.swap  <= 1'b0;
    end else if (wr_en) begin
      case (reg_index)
        rab_pkg::REG_COLOR: cfg.color <= pwdata[15:0];
        rab_pkg::REG_ALPHA: cfg.alpha <= pwdata[7:0];
        rab_pkg::REG_SWAP:  cfg.swap  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rab_pkg::REG_COLOR: prdata = {16'd0, cfg.color};
      rab_pkg::REG_ALPHA: prdata = {24'd0, cfg.alpha};
      rab_pkg::REG_SWAP:  prdata = {31'd0, cfg.swap};
      default:            prdata = '0;
    endcase
  end

  assign pixel_stall = !pixel_ready;

  rab_widen u_widen (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (pixel_valid),
    .in_ready     (pixel_ready),
    .stored_pixel (stored_pixel),
    .valid        (widen_valid),
    .out_ready    (mix_ready),
    .stage        (widen_stage)
  );

  rab_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .alpha     (cfg.alpha),
    .in_valid  (widen_valid),
    .in_ready  (mix_ready),
    .in_stage  (widen_stage),
    .valid     (mix_valid),
    .out_ready (scale_ready),
    .stage     (mix_stage)
  );

  rab_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mix_valid),
    .in_ready  (scale_ready),
    .in_stage  (mix_stage),
    .valid     (result_valid),
    .out_ready (!result_stall),
    .pixel     (blended_pixel)
  );

endmodule
`default_nettype wire

// ===== sim/rgb565_alpha_blend_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_alpha_blend_core_test
// Checks the constant-alpha RGB565 blend core against a predictor kept in
// step with the APB register writes. A short directed pass covers the alpha
// extremes, byte-swapped storage, unknown register addresses and surplus
// write bits. A random pass follows, over many register settings, with bursty
// input traffic, a result side that stalls on its own pattern and one long
// hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module rgb565_alpha_blend_core_test;

  localparam logic [1:0] REG_UNUSED    = 2'd3;
  localparam int         PIPE_LATENCY  = 3;
  localparam int         RANDOM_PHASES = 10;
  localparam int         PHASE_PIXELS  = 150;
  localparam int         CYCLE_LIMIT   = 400000;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

  class blend_scoreboard;
    logic [15:0] color;
    logic [7:0]  alpha;
    logic        swap;
    logic [15:0] expected_pixels[$];
    int unsigned failures;

    function new();
      color    = '0;
      alpha    = '0;
      swap     = 1'b0;
      failures = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        rab_pkg::REG_COLOR: color = data[15:0];
        rab_pkg::REG_ALPHA: alpha = data[7:0];
        rab_pkg::REG_SWAP:  swap  = data[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] swap_bytes(logic [15:0] word);
      return swap ? {word[7:0], word[15:8]} : word;
    endfunction

    // Widen both channels to 8 bits, mix, then narrow back by sh bits.
    function int unsigned mix_channel(int unsigned src, int unsigned dst,
                                      int unsigned maxv, int unsigned sh);
      int unsigned s8;
      int unsigned d8;
      int unsigned v;
      s8 = (src * 255) / maxv;
      d8 = (dst * 255) / maxv;
      v  = (s8 * alpha + d8 * (255 - alpha)) / 255;
      return (v >> sh) & maxv;
    endfunction

    function void queue_blend(logic [15:0] stored);
      logic [15:0] native;
      logic [15:0] mixed;
      if (alpha == rab_pkg::ALPHA_ZERO) begin
        expected_pixels.push_back(stored);
      end else if (alpha == rab_pkg::ALPHA_FULL) begin
        expected_pixels.push_back(swap_bytes(color));
      end else begin
        native        = swap_bytes(stored);
        mixed[15:11]  = 5'(mix_channel(color[15:11], native[15:11], 31, 3));
        mixed[10:5]   = 6'(mix_channel(color[10:5], native[10:5], 63, 2));
        mixed[4:0]    = 5'(mix_channel(color[4:0], native[4:0], 31, 3));
        expected_pixels.push_back(swap_bytes(mixed));
      end
    endfunction

    function void check_blend(logic [15:0] actual);
      logic [15:0] want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected transfer: blended_pixel %h with nothing pending", actual);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (actual !== want) begin
          $error("blended_pixel mismatch: expected %h, actual %h", want, actual);
          failures++;
        end
      end
    endfunction
  endclass

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [rab_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [rab_pkg::DATA_W-1:0]   pwdata       = '0;
  logic [rab_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         pixel_valid  = 1'b0;
  logic                         pixel_stall;
  logic [15:0]                  stored_pixel = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic [15:0]                  blended_pixel;

  blend_scoreboard sb = new();
  logic [15:0]     pixel_feed[$];
  bit              hold_pending = 1'b0;
  int              cycle_count  = 0;

  rgb565_alpha_blend_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .stored_pixel (stored_pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .blended_pixel(blended_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check every transfer, then pick the stall for the next edge.
  initial begin : result_side
    rx_mode_t    mode;
    int unsigned left;
    mode = RX_FLOW;
    left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall) begin
        sb.check_blend(blended_pixel);
      end
      if (left == 0) begin
        if (hold_pending) begin
          hold_pending = 1'b0;
          mode = RX_HOLD;
          left = 300;
        end else begin
          case ($urandom_range(0, 9))
            0:       mode = RX_HOLD;
            1, 2, 3: mode = RX_FLOW;
            4, 5, 6: mode = RX_LIGHT;
            default: mode = RX_HEAVY;
          endcase
          left = (mode == RX_HOLD) ? $urandom_range(100, 250) : $urandom_range(10, 150);
        end
      end
      left--;
      case (mode)
        RX_FLOW:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
        default:  result_stall <= 1'b1;
      endcase
    end
  end

  task automatic apb_write(logic [1:0] index, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(index, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer the queued pixels in bursts; hold each one until it transfers.
  task automatic send_pixels();
    int unsigned burst;
    int unsigned gap;
    while (pixel_feed.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && pixel_feed.size() != 0) begin
        pixel_valid  <= 1'b1;
        stored_pixel <= pixel_feed[0];
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        sb.queue_blend(pixel_feed.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pixel_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] color;
    logic [7:0]  alpha;
    logic [31:0] data;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset: alpha zero passes pixels through.
    pixel_feed = '{16'h0000, 16'hFFFF, 16'hA5C3};
    send_pixels();
    wait_idle();
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    pixel_feed = '{16'h5A3C};
    send_pixels();
    wait_idle();

    // Opaque: the color replaces the pixel, in either byte order.
    apb_write(rab_pkg::REG_COLOR, 32'h0000_F81F);
    apb_write(rab_pkg::REG_ALPHA, {24'h0, rab_pkg::ALPHA_FULL});
    pixel_feed = '{16'h0000, 16'hFFFF};
    send_pixels();
    wait_idle();
    apb_write(rab_pkg::REG_SWAP, 32'h0000_0001);
    pixel_feed = '{16'h1234};
    send_pixels();
    wait_idle();

    // Surplus upper bits on every register must be dropped.
    apb_write(rab_pkg::REG_ALPHA, 32'hFFFF_FF80);
    apb_write(rab_pkg::REG_COLOR, 32'hFFFF_07E0);
    apb_write(rab_pkg::REG_SWAP, 32'hFFFF_FFFE);
    pixel_feed = '{16'h0000, 16'hFFFF, 16'hF800, 16'h001F};
    send_pixels();
    wait_idle();

    apb_write(rab_pkg::REG_ALPHA, 32'h0000_0001);
    apb_write(rab_pkg::REG_COLOR, 32'h0000_FFFF);
    pixel_feed = '{16'h0000, 16'hFFFF};
    send_pixels();
    wait_idle();
    apb_write(rab_pkg::REG_ALPHA, 32'h0000_00FE);
    apb_write(rab_pkg::REG_COLOR, 32'h0000_0000);
    pixel_feed = '{16'hFFFF, 16'h0000};
    send_pixels();
    wait_idle();
    apb_write(rab_pkg::REG_SWAP, 32'h0000_0001);
    apb_write(rab_pkg::REG_ALPHA, 32'h0000_0055);
    apb_write(rab_pkg::REG_COLOR, 32'h0000_1F00);
    pixel_feed = '{16'h00F8, 16'hE007, 16'h1234};
    send_pixels();
    wait_idle();

    // Random settings; the first phase gets the long result hold-off.
    hold_pending = 1'b1;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       color = 16'h0000;
        1:       color = 16'hFFFF;
        default: color = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       alpha = rab_pkg::ALPHA_ZERO;
        1:       alpha = rab_pkg::ALPHA_FULL;
        2:       alpha = 8'd1;
        3:       alpha = 8'd254;
        default: alpha = 8'($urandom_range(0, 255));
      endcase
      data = $urandom();
      data[15:0] = color;
      apb_write(rab_pkg::REG_COLOR, data);
      data = $urandom();
      data[7:0] = alpha;
      apb_write(rab_pkg::REG_ALPHA, data);
      apb_write(rab_pkg::REG_SWAP, $urandom());
      if ($urandom_range(0, 3) == 0) apb_write(REG_UNUSED, $urandom());
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        case ($urandom_range(0, 15))
          0:       pixel_feed.push_back(16'h0000);
          1:       pixel_feed.push_back(16'hFFFF);
          default: pixel_feed.push_back(16'($urandom_range(0, 65535)));
        endcase
      end
      send_pixels();
      wait_idle();
    end

    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rab_pkg.sv
hdl/rab_widen.sv
hdl/rab_mix.sv
hdl/rab_scale.sv
hdl/rgb565_alpha_blend_core.sv
sim/rgb565_alpha_blend_core_test.sv
